/* rtl/rss_pkg.sv */
package rss_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned SUM_BITS    = 32;
  localparam int unsigned SQSUM_BITS  = 47;
  localparam int unsigned MAG_BITS    = 32;
  localparam int unsigned ACC_BITS    = 64;
  localparam int unsigned DEN_BITS    = 32;
  localparam int unsigned MEAN_BITS   = 24;
  localparam int unsigned VAR_BITS    = 31;
  localparam int unsigned STD_BITS    = 16;
  localparam int unsigned OUT_BITS    = 120;
  localparam int unsigned STEP_BITS   = $clog2(MAG_BITS + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP =
    {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM =
    {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [VAR_BITS-1:0] VAR_MAX = {VAR_BITS{1'b1}};

  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_CLEAR      = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_UPDATE,
    ST_PREP,
    ST_NSQ,
    ST_SSQ,
    ST_VDIV,
    ST_VWAIT,
    ST_SQRT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic busy;
    logic ovf;
  } rss_stat_t;

endpackage

/* rtl/rss_div.sv */
module rss_div import rss_pkg::*; #(
  parameter int unsigned VW = 16,
  parameter int unsigned QW = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VW+QW-1:0] dividend_i,
  input  logic [VW-1:0]    divisor_i,
  output logic [QW-1:0]    quotient_o,
  output rss_stat_t        stat_o
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic [VW-1:0] rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [VW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          ovf_q;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  always_comb begin
    trial = {rem_q, quo_q[QW-1]};
    diff  = trial - {1'b0, div_q};
    fits  = trial >= {1'b0, div_q};
    rem_d = fits ? diff[VW-1:0] : trial[VW-1:0];
    quo_d = {quo_q[QW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      ovf_q  <= dividend_i[VW+QW-1:QW] >= divisor_i;
      cnt_q  <= CW'(QW);
    end else if (busy_q) begin
      busy_q <= cnt_q != CW'(1);
      cnt_q  <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[VW+QW-1:QW];
      quo_q <= dividend_i[QW-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.ovf  = ovf_q;

endmodule

/* rtl/rss_sqrt.sv */
module rss_sqrt import rss_pkg::*; #(
  parameter int unsigned RW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RW-1:0] radicand_i,
  output logic [RW-1:0]   root_o,
  output rss_stat_t       stat_o
);

  localparam int unsigned CW = $clog2(RW + 1);

  logic [2*RW-1:0] rad_q;
  logic [RW:0]     rem_q;
  logic [RW-1:0]   root_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;
  logic [RW+2:0]   rem_sh;
  logic [RW+2:0]   trial;
  logic [RW+2:0]   diff;
  logic            fits;

  always_comb begin
    rem_sh = {rem_q, rad_q[2*RW-1:2*RW-2]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = rem_sh - trial;
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(RW);
    end else if (busy_q) begin
      busy_q <= cnt_q != CW'(1);
      cnt_q  <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[2*RW-3:0], 2'b00};
      rem_q  <= fits ? diff[RW:0] : rem_sh[RW:0];
      root_q <= {root_q[RW-2:0], fits};
    end
  end

  assign root_o      = root_q;
  assign stat_o.busy = busy_q;
  assign stat_o.ovf  = 1'b0;

endmodule

/* rtl/running_sample_statistics.sv */
// Running statistics over signed 16-bit samples: each request either adds a sample or
// clears the statistics, and each gives one result with count, minimum, maximum, mean
// (8 fraction bits, truncated toward zero), sample variance (saturating at 2^31-1, zero
// below two samples) and its floor square root; tuser of a result flags a sample dropped
// because the count was full. One request is worked at a time, and no new request is
// accepted until its result has been placed in the output register. The work is done by the
// bit-serial multiply-accumulate, one multiplier bit per cycle (for the square, for count
// times sum of squares and for the squared sum), by the variance divider at one quotient
// bit per cycle and by the square root at two radicand bits per cycle;
// the mean divider runs beside the multiply-accumulate. A finished result waits in an
// output register while the next request is accepted.
module running_sample_statistics import rss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [15:0]         s_axis_tdata_i,  // sample[15:0]
  input  logic                s_axis_tuser_i,  // command
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OUT_BITS-1:0] m_axis_tdata_o,  // sample_count, minimum, maximum, mean,
                                               // variance, std_dev, zero pad
  output logic                m_axis_tuser_o   // saturated
);

  state_e state_q, state_d;

  logic                          cmd_q, cmd_d;
  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic [ACC_BITS-1:0]           acc_q, acc_d;
  logic [ACC_BITS-1:0]           mcand_q, mcand_d;
  logic [MAG_BITS-1:0]           mplier_q, mplier_d;
  logic [DEN_BITS-1:0]           den_acc_q, den_acc_d;
  logic [DEN_BITS-1:0]           den_mcand_q, den_mcand_d;
  logic [COUNT_BITS-1:0]         den_mplier_q, den_mplier_d;
  logic [STEP_BITS-1:0]          step_q, step_d;
  logic [VAR_BITS-1:0]           var_q, var_d;
  logic                          sat_q, sat_d;

  logic [COUNT_BITS-1:0]         count_q, count_d;
  logic signed [SUM_BITS-1:0]    sum_q, sum_d;
  logic [SQSUM_BITS-1:0]         sqsum_q, sqsum_d;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d;
  logic signed [SAMPLE_BITS-1:0] max_q, max_d;

  logic                          out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0]           out_data_q, out_data_d;
  logic                          out_sat_q, out_sat_d;

  logic                          in_fire;
  logic [SAMPLE_BITS-1:0]        x_mag_in;
  logic [MAG_BITS-1:0]           sum_mag;
  logic [ACC_BITS-1:0]           mac_addend;
  logic [DEN_BITS-1:0]           den_addend;

  logic                          mean_start;
  logic [MEAN_BITS-1:0]          mean_quo;
  rss_stat_t                     mean_stat;
  logic [MEAN_BITS-1:0]          mean_val;

  logic                          var_start;
  logic [DEN_BITS+VAR_BITS-1:0]  var_dividend;
  logic [VAR_BITS-1:0]           var_quo;
  rss_stat_t                     var_stat;
  logic [VAR_BITS-1:0]           var_val;

  logic                          sqrt_start;
  logic [STD_BITS-1:0]           std_val;
  rss_stat_t                     sqrt_stat;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign x_mag_in = s_axis_tdata_i[SAMPLE_BITS-1] ? (~s_axis_tdata_i + SAMPLE_BITS'(1))
                                                  : s_axis_tdata_i;
  assign sum_mag  = sum_q[SUM_BITS-1] ? MAG_BITS'(-sum_q) : MAG_BITS'(sum_q);

  assign mac_addend = mplier_q[0] ? mcand_q : '0;
  assign den_addend = den_mplier_q[0] ? den_mcand_q : '0;

  assign var_dividend = acc_q[ACC_BITS-1] ? '0 : acc_q[DEN_BITS+VAR_BITS-1:0];

  always_comb begin
    if (count_q == '0) begin
      mean_val = '0;
    end else if (sum_q[SUM_BITS-1]) begin
      mean_val = -mean_quo;
    end else begin
      mean_val = mean_quo;
    end
  end

  always_comb begin
    if (count_q < COUNT_BITS'(2)) begin
      var_val = '0;
    end else if (var_stat.ovf) begin
      var_val = VAR_MAX;
    end else begin
      var_val = var_quo;
    end
  end

  rss_div #(
    .VW (COUNT_BITS),
    .QW (MEAN_BITS)
  ) u_mean_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mean_start),
    .dividend_i ({sum_mag, FRAC_BITS'(0)}),
    .divisor_i  (count_q),
    .quotient_o (mean_quo),
    .stat_o     (mean_stat)
  );

  rss_div #(
    .VW (DEN_BITS),
    .QW (VAR_BITS)
  ) u_var_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (var_start),
    .dividend_i (var_dividend),
    .divisor_i  (den_acc_q),
    .quotient_o (var_quo),
    .stat_o     (var_stat)
  );

  rss_sqrt #(
    .RW (STD_BITS)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i ({1'b0, var_d}),
    .root_o     (std_val),
    .stat_o     (sqrt_stat)
  );

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    x_d          = x_q;
    acc_d        = acc_q;
    mcand_d      = mcand_q;
    mplier_d     = mplier_q;
    den_acc_d    = den_acc_q;
    den_mcand_d  = den_mcand_q;
    den_mplier_d = den_mplier_q;
    step_d       = step_q;
    var_d        = var_q;
    sat_d        = sat_q;
    count_d      = count_q;
    sum_d        = sum_q;
    sqsum_d      = sqsum_q;
    min_d        = min_q;
    max_d        = max_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_sat_d    = out_sat_q;
    mean_start   = 1'b0;
    var_start    = 1'b0;
    sqrt_start   = 1'b0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d    = s_axis_tuser_i;
          x_d      = s_axis_tdata_i;
          acc_d    = '0;
          mcand_d  = ACC_BITS'(x_mag_in);
          mplier_d = MAG_BITS'(x_mag_in);
          step_d   = STEP_BITS'(SAMPLE_BITS);
          state_d  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        acc_d    = acc_q + mac_addend;
        mcand_d  = {mcand_q[ACC_BITS-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[MAG_BITS-1:1]};
        step_d   = step_q - STEP_BITS'(1);
        if (step_q == STEP_BITS'(1)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        sat_d = 1'b0;
        if (cmd_q == CMD_CLEAR) begin
          count_d = '0;
          sum_d   = '0;
          sqsum_d = '0;
          min_d   = SAMPLE_TOP;
          max_d   = SAMPLE_BOTTOM;
        end else if (count_q == COUNT_MAX) begin
          sat_d = 1'b1;
        end else begin
          count_d = count_q + COUNT_BITS'(1);
          sum_d   = sum_q + {{(SUM_BITS-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
          sqsum_d = sqsum_q + acc_q[SQSUM_BITS-1:0];
          if (x_q > max_q) begin
            max_d = x_q;
          end
          if (x_q < min_q) begin
            min_d = x_q;
          end
        end
        state_d = ST_PREP;
      end
      ST_PREP: begin
        mean_start   = 1'b1;
        acc_d        = '0;
        mcand_d      = ACC_BITS'(sqsum_q);
        mplier_d     = MAG_BITS'(count_q);
        den_acc_d    = '0;
        den_mcand_d  = DEN_BITS'(count_q);
        den_mplier_d = count_q - COUNT_BITS'(1);
        step_d       = STEP_BITS'(COUNT_BITS);
        state_d      = ST_NSQ;
      end
      ST_NSQ: begin
        acc_d        = acc_q + mac_addend;
        mcand_d      = {mcand_q[ACC_BITS-2:0], 1'b0};
        mplier_d     = {1'b0, mplier_q[MAG_BITS-1:1]};
        den_acc_d    = den_acc_q + den_addend;
        den_mcand_d  = {den_mcand_q[DEN_BITS-2:0], 1'b0};
        den_mplier_d = {1'b0, den_mplier_q[COUNT_BITS-1:1]};
        step_d       = step_q - STEP_BITS'(1);
        if (step_q == STEP_BITS'(1)) begin
          mcand_d  = ACC_BITS'(sum_mag);
          mplier_d = sum_mag;
          step_d   = STEP_BITS'(MAG_BITS);
          state_d  = ST_SSQ;
        end
      end
      ST_SSQ: begin
        acc_d    = acc_q - mac_addend;
        mcand_d  = {mcand_q[ACC_BITS-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[MAG_BITS-1:1]};
        step_d   = step_q - STEP_BITS'(1);
        if (step_q == STEP_BITS'(1)) begin
          state_d = ST_VDIV;
        end
      end
      ST_VDIV: begin
        var_start = 1'b1;
        state_d   = ST_VWAIT;
      end
      ST_VWAIT: begin
        if (!var_stat.busy && !mean_stat.busy) begin
          var_d      = var_val;
          sqrt_start = 1'b1;
          state_d    = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (!sqrt_stat.busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_data_d  = {1'b0, std_val, var_q, mean_val, max_q, min_q, count_q};
          out_sat_d   = sat_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      sqsum_q     <= '0;
      min_q       <= SAMPLE_TOP;
      max_q       <= SAMPLE_BOTTOM;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      sqsum_q     <= sqsum_d;
      min_q       <= min_d;
      max_q       <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    x_q          <= x_d;
    acc_q        <= acc_d;
    mcand_q      <= mcand_d;
    mplier_q     <= mplier_d;
    den_acc_q    <= den_acc_d;
    den_mcand_q  <= den_mcand_d;
    den_mplier_q <= den_mplier_d;
    var_q        <= var_d;
    sat_q        <= sat_d;
    out_data_q   <= out_data_d;
    out_sat_q    <= out_sat_d;
  end

  assign s_axis_tready_o = state_q == ST_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sat_q;

  a_accept_starts_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_SQUARE)
    else $error("accepted request did not start the square step");

  a_units_idle_at_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !mean_stat.busy && !var_stat.busy && !sqrt_stat.busy)
    else $error("result emitted while an arithmetic unit is still busy");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> min_q <= max_q)
    else $error("minimum above maximum with samples present");

  a_full_count_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && cmd_q == CMD_ACCUMULATE && count_q == COUNT_MAX)
      |=> $stable(sum_q) && $stable(count_q) && sat_q)
    else $error("sample taken while count full");

endmodule

/* dv/tb_running_sample_statistics.sv */
module tb_running_sample_statistics;
  import rss_pkg::*;

  localparam int MIN_LSB  = COUNT_BITS;
  localparam int MAX_LSB  = MIN_LSB + SAMPLE_BITS;
  localparam int MEAN_LSB = MAX_LSB + SAMPLE_BITS;
  localparam int VAR_LSB  = MEAN_LSB + MEAN_BITS;
  localparam int STD_LSB  = VAR_LSB + VAR_BITS;

  typedef struct {
    logic [COUNT_BITS-1:0]         sample_count;
    logic signed [SAMPLE_BITS-1:0] minimum;
    logic signed [SAMPLE_BITS-1:0] maximum;
    logic signed [MEAN_BITS-1:0]   mean;
    logic [VAR_BITS-1:0]           variance;
    logic [STD_BITS-1:0]           std_dev;
    logic                          saturated;
  } stats_t;

  class stats_tracker;
    logic [COUNT_BITS-1:0]         count_q;
    logic signed [SUM_BITS-1:0]    sum_q;
    logic [SQSUM_BITS-1:0]         sqsum_q;
    logic signed [SAMPLE_BITS-1:0] min_q;
    logic signed [SAMPLE_BITS-1:0] max_q;
    stats_t                        expected_q[$];
    int unsigned                   failures;

    function new();
      clear_stats();
      failures = 0;
    endfunction

    function void clear_stats();
      count_q = '0;
      sum_q   = '0;
      sqsum_q = '0;
      min_q   = SAMPLE_TOP;
      max_q   = SAMPLE_BOTTOM;
    endfunction

    function logic [STD_BITS-1:0] floor_root(logic [VAR_BITS-1:0] v);
      logic [STD_BITS-1:0] r;
      logic [STD_BITS-1:0] t;
      r = '0;
      for (int b = STD_BITS - 1; b >= 0; b--) begin
        t = r | (STD_BITS'(1) << b);
        if (longint'(t) * longint'(t) <= longint'(v)) r = t;
      end
      return r;
    endfunction

    function void note_request(logic cmd, logic [SAMPLE_BITS-1:0] raw);
      stats_t                        s;
      logic signed [SAMPLE_BITS-1:0] x;
      longint                        xl;
      longint                        sum_l;
      longint                        cnt_l;
      longint unsigned               n;
      longint unsigned               mag;
      longint unsigned               num_a;
      longint unsigned               num_b;
      longint unsigned               var_w;
      s.saturated = 1'b0;
      if (cmd == CMD_CLEAR) begin
        clear_stats();
      end else if (count_q == COUNT_MAX) begin
        s.saturated = 1'b1;
      end else begin
        x  = signed'(raw);
        xl = x;
        count_q = count_q + 1'b1;
        sum_q   = sum_q + x;
        sqsum_q = sqsum_q + SQSUM_BITS'(xl * xl);
        if (x > max_q) max_q = x;
        if (x < min_q) min_q = x;
      end
      n     = count_q;
      cnt_l = count_q;
      sum_l = sum_q;
      s.mean = '0;
      if (cnt_l != 0) s.mean = MEAN_BITS'((sum_l * 256) / cnt_l);
      var_w = 0;
      if (n >= 2) begin
        mag   = (sum_l < 0) ? -sum_l : sum_l;
        num_a = n * sqsum_q;
        num_b = mag * mag;
        if (num_a > num_b) var_w = (num_a - num_b) / (n * (n - 1));
        if (var_w > VAR_MAX) var_w = VAR_MAX;
      end
      s.sample_count = count_q;
      s.minimum      = min_q;
      s.maximum      = max_q;
      s.variance     = VAR_BITS'(var_w);
      s.std_dev      = floor_root(s.variance);
      expected_q.push_back(s);
    endfunction

    function void compare_field(string name, longint want_v, longint got_v);
      if (want_v != got_v) begin
        failures++;
        $error("%s: expected %0d, got %0d", name, want_v, got_v);
      end
    endfunction

    function void check_result(logic [OUT_BITS-1:0] data, logic user);
      stats_t want;
      stats_t got;
      if (expected_q.size() == 0) begin
        failures++;
        $error("result with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      got.sample_count = data[0 +: COUNT_BITS];
      got.minimum      = data[MIN_LSB +: SAMPLE_BITS];
      got.maximum      = data[MAX_LSB +: SAMPLE_BITS];
      got.mean         = data[MEAN_LSB +: MEAN_BITS];
      got.variance     = data[VAR_LSB +: VAR_BITS];
      got.std_dev      = data[STD_LSB +: STD_BITS];
      got.saturated    = user;
      compare_field("sample_count", want.sample_count, got.sample_count);
      compare_field("minimum", want.minimum, got.minimum);
      compare_field("maximum", want.maximum, got.maximum);
      compare_field("mean", want.mean, got.mean);
      compare_field("variance", want.variance, got.variance);
      compare_field("std_dev", want.std_dev, got.std_dev);
      compare_field("saturated", want.saturated, got.saturated);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_valid = 1'b0;
  logic [SAMPLE_BITS-1:0] s_data = '0;
  logic                   s_user = CMD_ACCUMULATE;
  logic                   m_ready = 1'b0;
  wire                    s_ready;
  wire                    m_valid;
  wire [OUT_BITS-1:0]     m_data;
  wire                    m_user;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  stats_tracker tracker = new();

  running_sample_statistics dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = 700;
    end
    if (hold_left > 0) begin
      m_ready <= 1'b0;
      hold_left--;
    end else begin
      m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (m_valid && m_ready) tracker.check_result(m_data, m_user);
  end

  task automatic send_request(logic cmd, logic [SAMPLE_BITS-1:0] smp);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= smp;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    tracker.note_request(cmd, smp);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [SAMPLE_BITS-1:0] v;
    case ($urandom_range(9))
      0: v = SAMPLE_TOP;
      1: v = SAMPLE_BOTTOM;
      2, 3: v = SAMPLE_BITS'($urandom_range(32) - 16);
      default: v = SAMPLE_BITS'($urandom);
    endcase
    return v;
  endfunction

  task automatic run_random(int items, int tx_pct, int rx_pct);
    logic cmd;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (items) begin
      cmd = ($urandom_range(99) < 3) ? CMD_CLEAR : CMD_ACCUMULATE;
      send_request(cmd, pick_sample());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(CMD_ACCUMULATE, SAMPLE_TOP);
    send_request(CMD_ACCUMULATE, SAMPLE_BOTTOM);
    send_request(CMD_CLEAR, 16'hFFFF);
    send_request(CMD_ACCUMULATE, SAMPLE_BOTTOM);
    send_request(CMD_CLEAR, 16'h0000);
    send_request(CMD_ACCUMULATE, 16'hFFFF);
    send_request(CMD_ACCUMULATE, 16'hFFFF);
    send_request(CMD_ACCUMULATE, 16'h0000);
    send_request(CMD_ACCUMULATE, 16'h0001);
    send_request(CMD_ACCUMULATE, 16'h5555);
    send_request(CMD_ACCUMULATE, 16'hAAAA);
    send_request(CMD_CLEAR, 16'h1234);
    send_request(CMD_CLEAR, 16'hFFFF);
    send_request(CMD_ACCUMULATE, SAMPLE_TOP);
    send_request(CMD_ACCUMULATE, SAMPLE_TOP);
    send_request(CMD_ACCUMULATE, 16'h0001);

    run_random(340, 38, 71);
    run_random(340, 71, 38);
    hold_seq++;
    run_random(340, 0, 0);

    send_request(CMD_CLEAR, pick_sample());
    send_request(CMD_ACCUMULATE, pick_sample());
    s_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("tb_running_sample_statistics: PASS");
    end else begin
      $display("tb_running_sample_statistics: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_running_sample_statistics: FAIL");
    $finish;
  end

endmodule
